### rtl/acc16_pkg.sv
// shared types, constants and control word layout of the accumulator cpu core
`default_nettype none

package acc16_pkg;

   localparam int MEM_WORDS = 1024;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int WORD_W    = 16;
   localparam int PC_OUT_W  = 10;

   localparam logic [3:0]        REG_ACC  = 4'd0;
   localparam logic [3:0]        REG_SP   = 4'd15;
   localparam logic [WORD_W-1:0] SP_RESET = 16'h0200;

   // request actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_EXEC  = 2'd2;

   typedef enum logic [3:0] {
      OP_SYS, OP_SET, OP_LD,  OP_ST,  OP_LDI, OP_STI, OP_POP, OP_PSH,
      OP_AND, OP_OR,  OP_ADD, OP_SUB, OP_NOT, OP_DEC, OP_INC, OP_XOR
   } opcode_type;

   // condition / function codes of the system opcode group
   localparam logic [3:0] SYS_BRA  = 4'h0;
   localparam logic [3:0] SYS_BGT  = 4'h1;
   localparam logic [3:0] SYS_BLT  = 4'h2;
   localparam logic [3:0] SYS_BGE  = 4'h3;
   localparam logic [3:0] SYS_BLE  = 4'h4;
   localparam logic [3:0] SYS_BNE  = 4'h5;
   localparam logic [3:0] SYS_BEQ  = 4'h6;
   localparam logic [3:0] SYS_JMPL = 4'h7;
   localparam logic [3:0] SYS_CALL = 4'h8;
   localparam logic [3:0] SYS_RET  = 4'h9;
   localparam logic [3:0] SYS_ADI  = 4'hA;
   localparam logic [3:0] SYS_SBI  = 4'hB;
   localparam logic [3:0] SYS_OUT  = 4'hC;
   localparam logic [3:0] SYS_JR0  = 4'hE;

   typedef struct packed {
      opcode_type op;
      logic [3:0] n;
   } decode_type;

   typedef enum logic [1:0] {MO_NONE, MO_RD, MO_WR} mem_op_type;
   typedef enum logic [1:0] {MA_PC, MA_REG, MA_R0, MA_REQ} maddr_type;
   typedef enum logic [1:0] {WD_R0, WD_PC, WD_REQ} wdata_type;
   typedef enum logic {RS_N, RS_15} rsel_type;
   typedef enum logic [3:0] {
      ALU_B, ALU_R0, ALU_MQ, ALU_AND, ALU_OR, ALU_ADD, ALU_SUB,
      ALU_XOR, ALU_NOT, ALU_DEC, ALU_INC, ALU_ADDI, ALU_SUBI
   } alu_type;
   typedef enum logic [1:0] {RD_NONE, RD_0, RD_N, RD_15} rdst_type;
   typedef enum logic [2:0] {PC_HOLD, PC_INC, PC_MQ, PC_A, PC_R0, PC_BR} pc_op_type;
   typedef enum logic [1:0] {NX_NEXT, NX_DISP, NX_END} next_type;

   typedef struct packed {
      mem_op_type mem;
      maddr_type  maddr;
      wdata_type  wdata;
      rsel_type   rsel;
      alu_type    alu;
      rdst_type   rdst;
      pc_op_type  pc_op;
      logic       ir_ld;
      logic       rdout;
      logic       chout;
      next_type   nxt;
   } ctrl_word_type;

   localparam ctrl_word_type CW_IDLE = '{
      mem:   MO_NONE,
      maddr: MA_PC,
      wdata: WD_R0,
      rsel:  RS_N,
      alu:   ALU_B,
      rdst:  RD_NONE,
      pc_op: PC_HOLD,
      ir_ld: 1'b0,
      rdout: 1'b0,
      chout: 1'b0,
      nxt:   NX_NEXT
   };

   typedef struct packed {
      logic [WORD_W-1:0]   read_word;
      logic                char_valid;
      logic [7:0]          char_out;
      logic [PC_OUT_W-1:0] program_counter;
      logic [WORD_W-1:0]   accumulator;
   } result_type;

endpackage

`default_nettype wire

### rtl/acc16_ram.sv
// single port word memory with registered read data
`default_nettype none

module acc16_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      // read data holds until the next read
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/acc16_useq.sv
// microcode sequencer: step counter, control rom and opcode dispatch
`default_nettype none

module acc16_useq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               action,
   input  acc16_pkg::decode_type    dec,
   input  logic                     hold,
   output acc16_pkg::ctrl_word_type ctrl,
   output logic                     step,
   output logic                     busy
);
   import acc16_pkg::*;

   localparam int UPC_W = 6;

   localparam logic [UPC_W-1:0] U_WRITE  = 6'd0;
   localparam logic [UPC_W-1:0] U_READ   = 6'd1;
   localparam logic [UPC_W-1:0] U_READ_2 = 6'd2;
   localparam logic [UPC_W-1:0] U_NONE   = 6'd3;
   localparam logic [UPC_W-1:0] U_FETCH  = 6'd4;
   localparam logic [UPC_W-1:0] U_DECODE = 6'd5;
   localparam logic [UPC_W-1:0] U_SET    = 6'd6;
   localparam logic [UPC_W-1:0] U_SET_2  = 6'd7;
   localparam logic [UPC_W-1:0] U_LD     = 6'd8;
   localparam logic [UPC_W-1:0] U_ST     = 6'd9;
   localparam logic [UPC_W-1:0] U_LDI    = 6'd10;
   localparam logic [UPC_W-1:0] U_LDI_2  = 6'd11;
   localparam logic [UPC_W-1:0] U_STI    = 6'd12;
   localparam logic [UPC_W-1:0] U_POP    = 6'd13;
   localparam logic [UPC_W-1:0] U_POP_2  = 6'd14;
   localparam logic [UPC_W-1:0] U_POP_3  = 6'd15;
   localparam logic [UPC_W-1:0] U_PSH    = 6'd16;
   localparam logic [UPC_W-1:0] U_PSH_2  = 6'd17;
   localparam logic [UPC_W-1:0] U_AND    = 6'd18;
   localparam logic [UPC_W-1:0] U_OR     = 6'd19;
   localparam logic [UPC_W-1:0] U_ADD    = 6'd20;
   localparam logic [UPC_W-1:0] U_SUB    = 6'd21;
   localparam logic [UPC_W-1:0] U_XOR    = 6'd22;
   localparam logic [UPC_W-1:0] U_NOT    = 6'd23;
   localparam logic [UPC_W-1:0] U_DEC    = 6'd24;
   localparam logic [UPC_W-1:0] U_INC    = 6'd25;
   localparam logic [UPC_W-1:0] U_BR     = 6'd26;
   localparam logic [UPC_W-1:0] U_JMPL   = 6'd27;
   localparam logic [UPC_W-1:0] U_JMPL_2 = 6'd28;
   localparam logic [UPC_W-1:0] U_CALL   = 6'd29;
   localparam logic [UPC_W-1:0] U_CALL_2 = 6'd30;
   localparam logic [UPC_W-1:0] U_RET    = 6'd31;
   localparam logic [UPC_W-1:0] U_RET_2  = 6'd32;
   localparam logic [UPC_W-1:0] U_ADI    = 6'd33;
   localparam logic [UPC_W-1:0] U_SBI    = 6'd34;
   localparam logic [UPC_W-1:0] U_OUT    = 6'd35;
   localparam logic [UPC_W-1:0] U_JR0    = 6'd36;
   localparam logic [UPC_W-1:0] U_JR0_2  = 6'd37;

   function automatic ctrl_word_type rom_word(input logic [UPC_W-1:0] a);
      ctrl_word_type w;
      w = CW_IDLE;
      case (a)
         U_WRITE: begin
            w.mem = MO_WR; w.maddr = MA_REQ; w.wdata = WD_REQ; w.nxt = NX_END;
         end
         U_READ: begin
            w.mem = MO_RD; w.maddr = MA_REQ;
         end
         U_READ_2: begin
            w.rdout = 1'b1; w.nxt = NX_END;
         end
         U_NONE: begin
            w.nxt = NX_END;
         end
         U_FETCH: begin
            w.mem = MO_RD; w.maddr = MA_PC; w.pc_op = PC_INC;
         end
         U_DECODE: begin
            w.ir_ld = 1'b1; w.nxt = NX_DISP;
         end
         U_SET: begin
            w.mem = MO_RD; w.maddr = MA_PC; w.pc_op = PC_INC;
         end
         U_SET_2: begin
            w.alu = ALU_MQ; w.rdst = RD_N; w.nxt = NX_END;
         end
         U_LD: begin
            w.alu = ALU_B; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_ST: begin
            w.alu = ALU_R0; w.rdst = RD_N; w.nxt = NX_END;
         end
         U_LDI: begin
            w.mem = MO_RD; w.maddr = MA_REG;
         end
         U_LDI_2: begin
            w.alu = ALU_MQ; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_STI: begin
            w.mem = MO_WR; w.maddr = MA_REG; w.wdata = WD_R0; w.nxt = NX_END;
         end
         U_POP: begin
            w.mem = MO_RD; w.maddr = MA_REG;
         end
         U_POP_2: begin
            w.alu = ALU_MQ; w.rdst = RD_0;
         end
         U_POP_3: begin
            // pointer is read again so that a pop through r0 bumps the loaded value
            w.alu = ALU_INC; w.rdst = RD_N; w.nxt = NX_END;
         end
         U_PSH: begin
            w.alu = ALU_DEC; w.rdst = RD_N;
         end
         U_PSH_2: begin
            w.mem = MO_WR; w.maddr = MA_REG; w.wdata = WD_R0; w.nxt = NX_END;
         end
         U_AND: begin
            w.alu = ALU_AND; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_OR: begin
            w.alu = ALU_OR; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_ADD: begin
            w.alu = ALU_ADD; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_SUB: begin
            w.alu = ALU_SUB; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_XOR: begin
            w.alu = ALU_XOR; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_NOT: begin
            w.alu = ALU_NOT; w.rdst = RD_N; w.nxt = NX_END;
         end
         U_DEC: begin
            w.alu = ALU_DEC; w.rdst = RD_N; w.nxt = NX_END;
         end
         U_INC: begin
            w.alu = ALU_INC; w.rdst = RD_N; w.nxt = NX_END;
         end
         U_BR: begin
            w.pc_op = PC_BR; w.nxt = NX_END;
         end
         U_JMPL: begin
            w.mem = MO_RD; w.maddr = MA_PC;
         end
         U_JMPL_2: begin
            w.pc_op = PC_MQ; w.nxt = NX_END;
         end
         U_CALL: begin
            w.rsel = RS_15; w.alu = ALU_DEC; w.rdst = RD_15;
         end
         U_CALL_2: begin
            w.rsel = RS_15; w.mem = MO_WR; w.maddr = MA_REG; w.wdata = WD_PC;
            w.pc_op = PC_A; w.nxt = NX_END;
         end
         U_RET: begin
            w.rsel = RS_15; w.mem = MO_RD; w.maddr = MA_REG;
         end
         U_RET_2: begin
            w.rsel = RS_15; w.pc_op = PC_MQ; w.alu = ALU_INC; w.rdst = RD_15;
            w.nxt = NX_END;
         end
         U_ADI: begin
            w.alu = ALU_ADDI; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_SBI: begin
            w.alu = ALU_SUBI; w.rdst = RD_0; w.nxt = NX_END;
         end
         U_OUT: begin
            w.chout = 1'b1; w.nxt = NX_END;
         end
         U_JR0: begin
            w.mem = MO_RD; w.maddr = MA_R0; w.pc_op = PC_R0;
         end
         U_JR0_2: begin
            w.alu = ALU_MQ; w.rdst = RD_0; w.nxt = NX_END;
         end
         default: begin
            w.nxt = NX_END;
         end
      endcase
      return w;
   endfunction

   function automatic logic [UPC_W-1:0] dispatch(input decode_type d);
      logic [UPC_W-1:0] t;
      case (d.op)
         OP_SET: t = U_SET;
         OP_LD:  t = U_LD;
         OP_ST:  t = U_ST;
         OP_LDI: t = U_LDI;
         OP_STI: t = U_STI;
         OP_POP: t = U_POP;
         OP_PSH: t = U_PSH;
         OP_AND: t = U_AND;
         OP_OR:  t = U_OR;
         OP_ADD: t = U_ADD;
         OP_SUB: t = U_SUB;
         OP_NOT: t = U_NOT;
         OP_DEC: t = U_DEC;
         OP_INC: t = U_INC;
         OP_XOR: t = U_XOR;
         OP_SYS: begin
            if (d.n <= SYS_BEQ) begin
               t = U_BR;
            end else begin
               case (d.n)
                  SYS_JMPL: t = U_JMPL;
                  SYS_CALL: t = U_CALL;
                  SYS_RET:  t = U_RET;
                  SYS_ADI:  t = U_ADI;
                  SYS_SBI:  t = U_SBI;
                  SYS_OUT:  t = U_OUT;
                  SYS_JR0:  t = U_JR0;
                  default:  t = U_NONE;
               endcase
            end
         end
         default: t = U_NONE;
      endcase
      return t;
   endfunction

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;

   always_comb begin
      ctrl = busy_ff ? rom_word(upc_ff) : CW_IDLE;
      step = busy_ff && !hold;
   end

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (start) begin
         busy_in = 1'b1;
         case (action)
            ACT_WRITE: upc_in = U_WRITE;
            ACT_READ:  upc_in = U_READ;
            ACT_EXEC:  upc_in = U_FETCH;
            default:   upc_in = U_NONE;
         endcase
      end else if (step) begin
         case (ctrl.nxt)
            NX_NEXT: upc_in  = upc_ff + 1'b1;
            NX_DISP: upc_in  = dispatch(dec);
            NX_END:  busy_in = 1'b0;
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= U_NONE;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

### rtl/acc16_dpath.sv
// datapath: register file, alu, program counter, instruction register and memory port
`default_nettype none

module acc16_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [9:0]               req_mem_address,
   input  logic [15:0]              req_write_word,
   input  acc16_pkg::ctrl_word_type ctrl,
   input  logic                     step,
   output logic                     clear_busy,
   output acc16_pkg::decode_type    dec,
   output acc16_pkg::result_type    result
);
   import acc16_pkg::*;

   function automatic logic branch_taken(input logic [3:0] cond, input logic [WORD_W-1:0] acc);
      logic neg, zero, t;
      neg  = acc[WORD_W-1];
      zero = (acc == '0);
      case (cond)
         SYS_BRA: t = 1'b1;
         SYS_BGT: t = !neg && !zero;
         SYS_BLT: t = neg;
         SYS_BGE: t = !neg;
         SYS_BLE: t = neg || zero;
         SYS_BNE: t = !zero;
         SYS_BEQ: t = zero;
         default: t = 1'b0;
      endcase
      return t;
   endfunction

   logic [WORD_W-1:0] regs_ff [16];
   logic [MEM_AW-1:0] pc_ff, pc_in;
   logic [WORD_W-1:0] ir_ff;
   logic [9:0]        req_addr_ff;
   logic [WORD_W-1:0] req_word_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [MEM_AW-1:0] clr_addr_ff, clr_addr_in;

   logic              mem_we, mem_re;
   logic [MEM_AW-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata, mq;

   logic [3:0]        ridx, widx;
   logic              reg_we;
   logic [WORD_W-1:0] rb, r0, imm, alu;

   acc16_ram #(
      .DEPTH(MEM_WORDS),
      .WIDTH(WORD_W)
   ) u_ram (
      .clock(clock),
      .we   (mem_we),
      .re   (mem_re),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mq)
   );

   always_comb begin
      ridx = (ctrl.rsel == RS_15) ? REG_SP : ir_ff[11:8];
      rb   = regs_ff[ridx];
      r0   = regs_ff[REG_ACC];
      imm  = {8'h00, ir_ff[7:0]};

      case (ctrl.alu)
         ALU_B:    alu = rb;
         ALU_R0:   alu = r0;
         ALU_MQ:   alu = mq;
         ALU_AND:  alu = r0 & rb;
         ALU_OR:   alu = r0 | rb;
         ALU_ADD:  alu = r0 + rb;
         ALU_SUB:  alu = r0 - rb;
         ALU_XOR:  alu = r0 ^ rb;
         ALU_NOT:  alu = ~rb;
         ALU_DEC:  alu = rb - 1'b1;
         ALU_INC:  alu = rb + 1'b1;
         ALU_ADDI: alu = r0 + imm;
         ALU_SUBI: alu = r0 - imm;
         default:  alu = rb;
      endcase

      case (ctrl.rdst)
         RD_0:    widx = REG_ACC;
         RD_N:    widx = ir_ff[11:8];
         RD_15:   widx = REG_SP;
         default: widx = REG_ACC;
      endcase
      reg_we = step && (ctrl.rdst != RD_NONE);

      case (ctrl.pc_op)
         PC_INC:  pc_in = pc_ff + 1'b1;
         PC_MQ:   pc_in = MEM_AW'(mq);
         PC_A:    pc_in = MEM_AW'(ir_ff[7:0]);
         PC_R0:   pc_in = MEM_AW'(r0);
         PC_BR:   pc_in = branch_taken(ir_ff[11:8], r0) ? MEM_AW'(ir_ff[7:0]) : pc_ff;
         default: pc_in = pc_ff;
      endcase
   end

   // memory port: the clearing pass after reset owns it until done
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == MEM_AW'(MEM_WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_re    = 1'b0;
         mem_addr  = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we = step && (ctrl.mem == MO_WR);
         mem_re = step && (ctrl.mem == MO_RD);
         case (ctrl.maddr)
            MA_PC:   mem_addr = pc_ff;
            MA_REG:  mem_addr = MEM_AW'(rb);
            MA_R0:   mem_addr = MEM_AW'(r0);
            MA_REQ:  mem_addr = MEM_AW'(req_addr_ff);
            default: mem_addr = pc_ff;
         endcase
         case (ctrl.wdata)
            WD_R0:   mem_wdata = r0;
            WD_PC:   mem_wdata = WORD_W'(pc_ff);
            WD_REQ:  mem_wdata = req_word_ff;
            default: mem_wdata = r0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff     <= '{REG_SP: SP_RESET, default: '0};
         pc_ff       <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         if (step) begin
            pc_ff <= pc_in;
         end
         if (reg_we) begin
            regs_ff[widx] <= alu;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_addr_ff <= req_mem_address;
         req_word_ff <= req_write_word;
      end
      if (step && ctrl.ir_ld) begin
         ir_ff <= mq;
      end
   end

   always_comb begin
      clear_busy = clr_busy_ff;
      dec.op     = opcode_type'(mq[15:12]);
      dec.n      = mq[11:8];

      // result reflects the state after the final step of the item
      result.read_word       = ctrl.rdout ? mq : '0;
      result.char_valid      = ctrl.chout;
      result.char_out        = ctrl.chout ? r0[7:0] : 8'h00;
      result.program_counter = PC_OUT_W'(pc_in);
      result.accumulator     = (reg_we && (widx == REG_ACC)) ? alu : r0;
   end

endmodule

`default_nettype wire

### rtl/accumulator_cpu_16bit_core.sv
// top level of the 16-bit accumulator cpu core: request handshake and result register
//
// Requests arrive on the req_ channel (req_action, req_mem_address, req_write_word);
// a transfer takes place when req_valid is high and req_stall is low. Each request
// gives exactly one result on the rsp_ channel, transferred when rsp_valid is high
// and rsp_stall is low. A request either writes a memory word, reads one, or
// fetches and runs one instruction; the unused action only gives a result.
// One request is worked on at a time by a microcoded sequencer; its memory is a
// single-port word RAM shared by fetch, immediate fetch and data access, so a
// request runs as a series of microcode steps after its transfer; an instruction
// takes the fetch and decode steps plus one to three execute steps.
// The result sits in an output register, so the next request is taken while the
// previous result waits; if the receiver stalls, the sequencer holds at the last
// step of the following request until the result register frees up.
// After reset the whole memory is cleared, one word per cycle; req_stall stays
// high during that pass. Registers reset to zero with r15 = 0x200.
`default_nettype none

module accumulator_cpu_16bit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [9:0]  req_mem_address,
   input  logic [15:0] req_write_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_word,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_char_out,
   output logic [9:0]  rsp_program_counter,
   output logic [15:0] rsp_accumulator
);
   import acc16_pkg::*;

   ctrl_word_type ctrl;
   decode_type    dec;
   result_type    result;
   result_type    rsp_res_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          busy, step, hold, start, clear_busy, load;

   acc16_useq u_useq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .action(req_action),
      .dec   (dec),
      .hold  (hold),
      .ctrl  (ctrl),
      .step  (step),
      .busy  (busy)
   );

   acc16_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_mem_address(req_mem_address),
      .req_write_word (req_write_word),
      .ctrl           (ctrl),
      .step           (step),
      .clear_busy     (clear_busy),
      .dec            (dec),
      .result         (result)
   );

   always_comb begin
      req_stall = busy || clear_busy;
      start     = req_valid && !req_stall;
      // last step waits while the previous result is still held
      hold      = (ctrl.nxt == NX_END) && rsp_valid_ff && rsp_stall;
      load      = step && (ctrl.nxt == NX_END);

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_res_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_word       = rsp_res_ff.read_word;
   assign rsp_char_valid      = rsp_res_ff.char_valid;
   assign rsp_char_out        = rsp_res_ff.char_out;
   assign rsp_program_counter = rsp_res_ff.program_counter;
   assign rsp_accumulator     = rsp_res_ff.accumulator;

endmodule

`default_nettype wire

### verif/acc16_result_checker.sv
// checker for the accumulator cpu core: predicts each result and compares it on transfer
module acc16_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [9:0]  req_mem_address,
   input  logic [15:0] req_write_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_read_word,
   input  logic        rsp_char_valid,
   input  logic [7:0]  rsp_char_out,
   input  logic [9:0]  rsp_program_counter,
   input  logic [15:0] rsp_accumulator,
   output int          fail_count,
   output int          pending,
   output logic [9:0]  model_pc
);
   timeunit 1ns;
   timeprecision 1ps;
   import acc16_pkg::*;

   logic [WORD_W-1:0] mem_model [MEM_WORDS];
   logic [WORD_W-1:0] reg_model [16];
   logic [MEM_AW-1:0] pc_model;
   result_type        expected_results [$];

   assign model_pc = pc_model;

   initial begin
      fail_count = 0;
      pending    = 0;
      pc_model   = '0;
   end

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t ns: %s got %h, expected %h", $time, field, got, want);
      fail_count++;
   endtask

   task automatic reset_model();
      for (int i = 0; i < MEM_WORDS; i++) mem_model[i] = '0;
      for (int i = 0; i < 16; i++) reg_model[i] = '0;
      reg_model[REG_SP] = SP_RESET;
      pc_model = '0;
   endtask

   // fetch, decode and run one instruction on the model state
   task automatic execute_instruction(output logic cv, output logic [7:0] ch);
      logic [15:0] ir;
      opcode_type  op;
      logic [3:0]  n;
      logic [7:0]  a;
      logic        neg;
      logic        zero;
      ir = mem_model[pc_model];
      pc_model = pc_model + 1'b1;
      op = opcode_type'(ir[15:12]);
      n  = ir[11:8];
      a  = ir[7:0];
      cv = 1'b0;
      ch = '0;
      case (op)
         OP_SET: begin
            reg_model[n] = mem_model[pc_model];
            pc_model = pc_model + 1'b1;
         end
         OP_LD:  reg_model[REG_ACC] = reg_model[n];
         OP_ST:  reg_model[n] = reg_model[REG_ACC];
         OP_LDI: reg_model[REG_ACC] = mem_model[reg_model[n][MEM_AW-1:0]];
         OP_STI: mem_model[reg_model[n][MEM_AW-1:0]] = reg_model[REG_ACC];
         OP_POP: begin
            reg_model[REG_ACC] = mem_model[reg_model[n][MEM_AW-1:0]];
            reg_model[n] = reg_model[n] + 1'b1;
         end
         OP_PSH: begin
            reg_model[n] = reg_model[n] - 1'b1;
            mem_model[reg_model[n][MEM_AW-1:0]] = reg_model[REG_ACC];
         end
         OP_AND: reg_model[REG_ACC] = reg_model[REG_ACC] & reg_model[n];
         OP_OR:  reg_model[REG_ACC] = reg_model[REG_ACC] | reg_model[n];
         OP_ADD: reg_model[REG_ACC] = reg_model[REG_ACC] + reg_model[n];
         OP_SUB: reg_model[REG_ACC] = reg_model[REG_ACC] - reg_model[n];
         OP_NOT: reg_model[n] = ~reg_model[n];
         OP_DEC: reg_model[n] = reg_model[n] - 1'b1;
         OP_INC: reg_model[n] = reg_model[n] + 1'b1;
         OP_XOR: reg_model[REG_ACC] = reg_model[REG_ACC] ^ reg_model[n];
         OP_SYS: begin
            neg  = reg_model[REG_ACC][15];
            zero = (reg_model[REG_ACC] == '0);
            case (n)
               SYS_BRA: pc_model = {2'b00, a};
               SYS_BGT: if (!neg && !zero) pc_model = {2'b00, a};
               SYS_BLT: if (neg) pc_model = {2'b00, a};
               SYS_BGE: if (!neg) pc_model = {2'b00, a};
               SYS_BLE: if (neg || zero) pc_model = {2'b00, a};
               SYS_BNE: if (!zero) pc_model = {2'b00, a};
               SYS_BEQ: if (zero) pc_model = {2'b00, a};
               SYS_JMPL: pc_model = mem_model[pc_model][MEM_AW-1:0];
               SYS_CALL: begin
                  reg_model[REG_SP] = reg_model[REG_SP] - 1'b1;
                  mem_model[reg_model[REG_SP][MEM_AW-1:0]] = {6'b0, pc_model};
                  pc_model = {2'b00, a};
               end
               SYS_RET: begin
                  pc_model = mem_model[reg_model[REG_SP][MEM_AW-1:0]][MEM_AW-1:0];
                  reg_model[REG_SP] = reg_model[REG_SP] + 1'b1;
               end
               SYS_ADI: reg_model[REG_ACC] = reg_model[REG_ACC] + {8'h00, a};
               SYS_SBI: reg_model[REG_ACC] = reg_model[REG_ACC] - {8'h00, a};
               SYS_OUT: begin
                  cv = 1'b1;
                  ch = reg_model[REG_ACC][7:0];
               end
               SYS_JR0: begin
                  pc_model = reg_model[REG_ACC][MEM_AW-1:0];
                  reg_model[REG_ACC] = mem_model[pc_model];
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      result_type want;
      logic       cv;
      logic [7:0] ch;
      if (reset) begin
         reset_model();
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            want = '0;
            cv   = 1'b0;
            ch   = '0;
            case (req_action)
               ACT_WRITE: mem_model[req_mem_address] = req_write_word;
               ACT_READ:  want.read_word = mem_model[req_mem_address];
               ACT_EXEC:  execute_instruction(cv, ch);
               default: ;
            endcase
            want.char_valid      = cv;
            want.char_out        = ch;
            want.program_counter = pc_model;
            want.accumulator     = reg_model[REG_ACC];
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending, accumulator",
                               rsp_accumulator, 16'h0000);
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_word !== want.read_word)
                  report_mismatch("read_word", rsp_read_word, want.read_word);
               if (rsp_char_valid !== want.char_valid)
                  report_mismatch("char_valid", {15'b0, rsp_char_valid},
                                  {15'b0, want.char_valid});
               if (rsp_char_out !== want.char_out)
                  report_mismatch("char_out", {8'b0, rsp_char_out}, {8'b0, want.char_out});
               if (rsp_program_counter !== want.program_counter)
                  report_mismatch("program_counter", {6'b0, rsp_program_counter},
                                  {6'b0, want.program_counter});
               if (rsp_accumulator !== want.accumulator)
                  report_mismatch("accumulator", rsp_accumulator, want.accumulator);
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

### verif/tb_accumulator_cpu_16bit_core.sv
// testbench top for the accumulator cpu core: stimulus, handshake pacing and verdict
module tb_accumulator_cpu_16bit_core;
   timeunit 1ns;
   timeprecision 1ps;
   import acc16_pkg::*;

   localparam logic [1:0] ACT_NONE   = 2'd3;
   localparam int         NUM_ITEMS  = 1250;
   localparam int         IDLE_LIMIT = 6000;
   localparam int         HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_WRITE;
   logic [9:0]  req_mem_address = '0;
   logic [15:0] req_write_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_read_word;
   logic        rsp_char_valid;
   logic [7:0]  rsp_char_out;
   logic [9:0]  rsp_program_counter;
   logic [15:0] rsp_accumulator;

   int          fail_count;
   int          pending;
   logic [9:0]  model_pc;
   int          sent_count = 0;
   int          quiet_cycles = 0;
   logic        calm;
   logic        held = 1'b0;

   // stretch with no idling on either side
   assign calm = (sent_count >= 500) && (sent_count < 800);

   accumulator_cpu_16bit_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_mem_address     (req_mem_address),
      .req_write_word      (req_write_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_word       (rsp_read_word),
      .rsp_char_valid      (rsp_char_valid),
      .rsp_char_out        (rsp_char_out),
      .rsp_program_counter (rsp_program_counter),
      .rsp_accumulator     (rsp_accumulator)
   );

   acc16_result_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_mem_address     (req_mem_address),
      .req_write_word      (req_write_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_word       (rsp_read_word),
      .rsp_char_valid      (rsp_char_valid),
      .rsp_char_out        (rsp_char_out),
      .rsp_program_counter (rsp_program_counter),
      .rsp_accumulator     (rsp_accumulator),
      .fail_count          (fail_count),
      .pending             (pending),
      .model_pc            (model_pc)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("accumulator_cpu_16bit_core: mismatch");
            $finish;
         end
      end
   end

   // receiver: random stalls, one long hold-off while requests keep coming
   initial begin
      forever begin
         @(negedge clock);
         if (!held && sent_count >= 200) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 30);
      end
   end

   function automatic logic [15:0] instr(input opcode_type op, input logic [3:0] n,
                                         input logic [7:0] a);
      return {op, n, a};
   endfunction

   function automatic logic [15:0] random_instr();
      logic [3:0] op;
      logic [3:0] n;
      logic [7:0] a;
      op = 4'($urandom_range(15));
      n  = 4'($urandom_range(15));
      a  = 8'($urandom_range(255));
      if ($urandom_range(99) < 30) op = OP_SYS;
      return {op, n, a};
   endfunction

   // pc_rel places the address relative to the predicted pc, resolved when driven
   task automatic send_item(input logic [1:0] act, input logic [9:0] adr,
                            input logic [15:0] wd, input logic pc_rel,
                            input logic [9:0] offset);
      while (!calm && $urandom_range(99) < 30) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_mem_address <= pc_rel ? model_pc + offset : adr;
      req_write_word  <= wd;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic send_random(input logic [1:0] act);
      send_item(act, 10'($urandom_range(1023)), 16'($urandom_range(65535)), 1'b0, '0);
   endtask

   initial begin
      int pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes and the unused action
      send_item(ACT_WRITE, 10'h3FF, 16'hFFFF, 1'b0, '0);
      send_item(ACT_READ,  10'h3FF, 16'h0000, 1'b0, '0);
      send_item(ACT_READ,  10'h000, 16'hFFFF, 1'b0, '0);
      send_item(ACT_NONE,  10'h155, 16'hAAAA, 1'b0, '0);
      // short program: immediate, output, branch, call, return, jump through r0 with wrap
      send_item(ACT_WRITE, 10'h000, instr(OP_SET, REG_ACC, 8'h00), 1'b0, '0);
      send_item(ACT_WRITE, 10'h001, 16'h8001, 1'b0, '0);
      send_item(ACT_WRITE, 10'h002, instr(OP_SYS, SYS_OUT, 8'h00), 1'b0, '0);
      send_item(ACT_WRITE, 10'h003, instr(OP_SYS, SYS_BLT, 8'h10), 1'b0, '0);
      send_item(ACT_WRITE, 10'h010, instr(OP_SYS, SYS_CALL, 8'hFF), 1'b0, '0);
      send_item(ACT_WRITE, 10'h0FF, instr(OP_SYS, SYS_RET, 8'h00), 1'b0, '0);
      send_item(ACT_WRITE, 10'h011, instr(OP_SYS, SYS_JR0, 8'h00), 1'b0, '0);
      repeat (10) send_item(ACT_EXEC, 10'h2AA, 16'h5555, 1'b0, '0);
      send_item(ACT_READ, 10'h1FF, 16'h0000, 1'b0, '0);

      while (sent_count < NUM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // well-formed step: instruction at pc, maybe an operand word, then run it
            send_item(ACT_WRITE, '0, random_instr(), 1'b1, 10'd0);
            if ($urandom_range(1))
               send_item(ACT_WRITE, '0, 16'($urandom_range(65535)), 1'b1, 10'd1);
            send_random(ACT_EXEC);
         end else if (pick < 75) begin
            send_random(ACT_EXEC);
         end else if (pick < 85) begin
            send_random(ACT_WRITE);
         end else if (pick < 95) begin
            send_random(ACT_READ);
         end else begin
            send_random(ACT_NONE);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("accumulator_cpu_16bit_core: match");
      else
         $display("accumulator_cpu_16bit_core: mismatch");
      $finish;
   end

endmodule

### accumulator_cpu_16bit_core.f
rtl/acc16_pkg.sv
rtl/acc16_ram.sv
rtl/acc16_useq.sv
rtl/acc16_dpath.sv
rtl/accumulator_cpu_16bit_core.sv
verif/acc16_result_checker.sv
verif/tb_accumulator_cpu_16bit_core.sv
